// ===== src/stt_pkg.sv =====
package stt_pkg;

    // Token kinds as carried on the result channel
    localparam logic [3:0] KIND_IDENT   = 4'd0;
    localparam logic [3:0] KIND_INT     = 4'd1;
    localparam logic [3:0] KIND_FLOAT   = 4'd2;
    localparam logic [3:0] KIND_STRING  = 4'd3;
    localparam logic [3:0] KIND_CHAR    = 4'd4;
    localparam logic [3:0] KIND_OP      = 4'd5;
    localparam logic [3:0] KIND_NEWLINE = 4'd6;
    localparam logic [3:0] KIND_INDENT  = 4'd7;
    localparam logic [3:0] KIND_EXDENT  = 4'd8;
    localparam logic [3:0] KIND_EOF     = 4'd9;

    // Configuration register indexes
    localparam logic [2:0] REG_NEWLINE_ON  = 3'd0;
    localparam logic [2:0] REG_INDENT_ON   = 3'd1;
    localparam logic [2:0] REG_LINE_LEN    = 3'd2;
    localparam logic [2:0] REG_LINE_TEXT   = 3'd3;
    localparam logic [2:0] REG_BOPEN_LEN   = 3'd4;
    localparam logic [2:0] REG_BOPEN_TEXT  = 3'd5;
    localparam logic [2:0] REG_BCLOSE_LEN  = 3'd6;
    localparam logic [2:0] REG_BCLOSE_TEXT = 3'd7;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_3      = 8'h33;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    typedef enum logic [3:0] {
        MODE_IDLE, MODE_IDENT, MODE_HEXX, MODE_HEX, MODE_DEC, MODE_FRAC,
        MODE_STR, MODE_CHR, MODE_LCOM, MODE_BCOM, MODE_SKIP1, MODE_SKIP2,
        MODE_SKIP3, MODE_OP2
    } t_mode;

    typedef enum logic {SEL_BYTES, SEL_CODE} t_sel;

    typedef enum logic [1:0] {OP_HEAD, OP_QUOTE, OP_EOF} t_op;

    typedef struct packed {
        t_mode      mode;
        logic       esc;
        logic       ls;
        logic [6:0] cols;
        logic [4:0] prev;
    } t_lex_state;

    typedef struct packed {
        logic        nl_on;
        logic        ind_on;
        logic [2:0]  lc_len;
        logic [31:0] lc_text;
        logic [2:0]  bo_len;
        logic [31:0] bo_text;
        logic [2:0]  bc_len;
        logic [31:0] bc_text;
    } t_cfg;

    // Main part of a result plan: one byte, a byte pair, or an escape code
    // (quote, comma, space, digits, comma, space, quote)
    typedef struct packed {
        logic [3:0] len;
        t_sel       sel;
        logic [3:0] kind;
        logic       has;
        logic       first;
        logic       last;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] d2;
    } t_main;

    typedef struct packed {
        logic [4:0] ind_cnt;
        logic       ind_ex;
        t_main      main;
    } t_plan;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER || c == CH_DOT;
    endfunction

    function automatic logic two_char_op(input logic [7:0] a, input logic [7:0] b);
        logic r;
        case (a)
            CH_PLUS:          r = b == CH_PLUS || b == CH_EQ;
            CH_MINUS:         r = b == CH_MINUS || b == CH_EQ;
            CH_STAR, CH_SLASH: r = b == CH_EQ;
            CH_EQ:            r = b == CH_EQ;
            CH_BAR:           r = b == CH_BAR;
            CH_AMP:           r = b == CH_AMP;
            CH_LT:            r = b == CH_EQ || b == CH_LT;
            CH_GT:            r = b == CH_EQ || b == CH_GT;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

    // Compare the window head with a delimiter; a zero byte that matches ends as a match
    function automatic logic delim_match(input logic [31:0] w, input logic [31:0] text,
                                         input logic [2:0] len);
        logic       ok;
        logic       stop;
        logic [7:0] a;
        logic [7:0] d;
        ok   = 1'b1;
        stop = 1'b0;
        for (int k = 0; k < 4; k++) begin
            a = w[8*k +: 8];
            d = text[8*k +: 8];
            if (3'(k) < len && !stop) begin
                if (a != d) begin
                    ok   = 1'b0;
                    stop = 1'b1;
                end else if (a == CH_NUL) begin
                    stop = 1'b1;
                end
            end
        end
        return ok;
    endfunction

    function automatic t_main plain_main(input logic [3:0] kind, input logic [7:0] b,
                                         input logic has, input logic first,
                                         input logic last);
        t_main m;
        m       = '0;
        m.len   = 4'd1;
        m.sel   = SEL_BYTES;
        m.kind  = kind;
        m.has   = has;
        m.first = first;
        m.last  = last;
        m.b0    = b;
        return m;
    endfunction

    function automatic t_main pair_main(input logic [3:0] kind, input logic [7:0] b0,
                                        input logic [7:0] b1, input logic last);
        t_main m;
        m      = '0;
        m.len  = 4'd2;
        m.sel  = SEL_BYTES;
        m.kind = kind;
        m.has  = 1'b1;
        m.last = last;
        m.b0   = b0;
        m.b1   = b1;
        return m;
    endfunction

    function automatic t_main code_main(input logic [3:0] kind, input logic [7:0] q,
                                        input logic [7:0] d1, input logic [7:0] d2,
                                        input logic two_digits);
        t_main m;
        m      = '0;
        m.len  = two_digits ? 4'd8 : 4'd7;
        m.sel  = SEL_CODE;
        m.kind = kind;
        m.has  = 1'b1;
        m.b0   = q;
        m.b1   = d1;
        m.d2   = d2;
        return m;
    endfunction

    function automatic logic [7:0] main_byte(input t_main m, input logic [3:0] idx);
        logic [7:0] b;
        if (m.sel == SEL_BYTES) begin
            b = (idx == 4'd0) ? m.b0 : m.b1;
        end else if (idx == 4'd0 || idx == m.len - 4'd1) begin
            b = m.b0;
        end else if (idx == 4'd2 || idx == m.len - 4'd2) begin
            b = CH_SPACE;
        end else if (idx == 4'd1 || idx == m.len - 4'd3) begin
            b = CH_COMMA;
        end else if (idx == 4'd3) begin
            b = m.b1;
        end else begin
            b = m.d2;
        end
        return b;
    endfunction

endpackage

// ===== src/stt_head.sv =====
module stt_head import stt_pkg::*; #(
    parameter int DELIM_BYTES       = 4,
    parameter int MAX_INDENT_LEVELS = 16
) (
    input  t_op        i_op,
    input  logic [31:0] i_head,
    input  t_lex_state i_state,
    input  t_cfg       i_cfg,
    output t_lex_state o_state,
    output t_plan      o_plan
);

    localparam logic [2:0] DCAP = (DELIM_BYTES >= 4) ? 3'd4 : 3'(DELIM_BYTES);
    localparam logic [4:0] MAXL = 5'(MAX_INDENT_LEVELS);

    function automatic logic [2:0] clamp_len(input logic [2:0] len);
        logic [2:0] l;
        l = (len > 3'd4) ? 3'd4 : len;
        return (l > DCAP) ? DCAP : l;
    endfunction

    always_comb begin
        logic [7:0] c;
        logic [7:0] nx;
        logic [7:0] q;
        logic [3:0] kind;
        logic [2:0] lc_len;
        logic [2:0] bo_len;
        logic [2:0] bc_len;
        logic       close_hit;
        t_mode      close_mode;
        logic [4:0] level;
        logic [4:0] fl_cnt;
        logic       fl_ex;
        logic [7:0] csum;
        logic       measuring;
        logic       run_idle;
        logic       more;
        t_lex_state st;
        t_plan      plan;

        c  = i_head[7:0];
        nx = i_head[15:8];
        st = i_state;
        plan = '0;
        measuring = 1'b0;
        run_idle  = 1'b0;
        more      = 1'b0;

        lc_len = clamp_len(i_cfg.lc_len);
        bo_len = clamp_len(i_cfg.bo_len);
        bc_len = clamp_len(i_cfg.bc_len);
        if (bc_len == 3'd0) begin
            bc_len = 3'd1;
        end
        close_hit = delim_match(i_head, i_cfg.bc_text, bc_len);
        case (bc_len)
            3'd2:    close_mode = MODE_SKIP1;
            3'd3:    close_mode = MODE_SKIP2;
            3'd4:    close_mode = MODE_SKIP3;
            default: close_mode = MODE_IDLE;
        endcase

        level = i_state.cols[6:2];
        if (level > MAXL) begin
            level = MAXL;
        end
        fl_ex  = !(level > i_state.prev);
        fl_cnt = fl_ex ? i_state.prev - level : level - i_state.prev;

        q    = (i_state.mode == MODE_STR) ? CH_DQUOTE : CH_SQUOTE;
        kind = (i_state.mode == MODE_STR) ? KIND_STRING : KIND_CHAR;
        csum = {1'b0, i_state.cols} + ((c == CH_TAB) ? 8'd4 : 8'd1);

        unique case (i_op)
            OP_HEAD: begin
                unique case (i_state.mode)
                    MODE_IDENT: begin
                        plan.main = plain_main(KIND_IDENT, c, 1'b1, 1'b0, !is_ident(nx));
                        if (!is_ident(nx)) begin
                            st.mode = MODE_IDLE;
                        end
                    end
                    MODE_HEXX: begin
                        plan.main = plain_main(KIND_INT, CH_LOW_X, 1'b1, 1'b0, !is_xdigit(nx));
                        st.mode = is_xdigit(nx) ? MODE_HEX : MODE_IDLE;
                    end
                    MODE_HEX: begin
                        plan.main = plain_main(KIND_INT, c, 1'b1, 1'b0, !is_xdigit(nx));
                        if (!is_xdigit(nx)) begin
                            st.mode = MODE_IDLE;
                        end
                    end
                    MODE_DEC: begin
                        if (c == CH_DOT) begin
                            plan.main = plain_main(KIND_FLOAT, CH_DOT, 1'b1, 1'b0,
                                                   !is_digit(nx));
                            st.mode = is_digit(nx) ? MODE_FRAC : MODE_IDLE;
                        end else begin
                            more = is_digit(nx) || nx == CH_DOT;
                            plan.main = plain_main(KIND_INT, c, 1'b1, 1'b0, !more);
                            if (!more) begin
                                st.mode = MODE_IDLE;
                            end
                        end
                    end
                    MODE_FRAC: begin
                        plan.main = plain_main(KIND_FLOAT, c, 1'b1, 1'b0, !is_digit(nx));
                        if (!is_digit(nx)) begin
                            st.mode = MODE_IDLE;
                        end
                    end
                    MODE_STR, MODE_CHR: begin
                        if (i_state.esc) begin
                            st.esc = 1'b0;
                            if (c == CH_LOW_N) begin
                                plan.main = code_main(kind, q, CH_1, CH_0, 1'b1);
                            end else if (c == CH_LOW_R) begin
                                plan.main = code_main(kind, q, CH_1, CH_3, 1'b1);
                            end else if (c == CH_LOW_T) begin
                                plan.main = code_main(kind, q, CH_9, CH_NUL, 1'b0);
                            end else if (c == q) begin
                                plan.main = pair_main(kind, CH_BSLASH, q, 1'b0);
                            end else begin
                                plan.main = plain_main(kind, c, 1'b1, 1'b0, 1'b0);
                            end
                        end else if (c == q) begin
                            plan.main = plain_main(kind, q, 1'b1, 1'b0, 1'b1);
                            st.mode = MODE_IDLE;
                        end else if (c == CH_BSLASH) begin
                            st.esc = 1'b1;
                        end else begin
                            plan.main = plain_main(kind, c, 1'b1, 1'b0, 1'b0);
                        end
                    end
                    MODE_LCOM: begin
                        if (c == CH_LF) begin
                            st.mode  = MODE_IDLE;
                            run_idle = 1'b1;
                        end
                    end
                    MODE_BCOM: begin
                        if (close_hit) begin
                            st.mode = close_mode;
                        end
                    end
                    MODE_SKIP1: st.mode = MODE_IDLE;
                    MODE_SKIP2: st.mode = MODE_SKIP1;
                    MODE_SKIP3: st.mode = MODE_SKIP2;
                    MODE_OP2: begin
                        plan.main = plain_main(KIND_OP, c, 1'b1, 1'b0, 1'b1);
                        st.mode = MODE_IDLE;
                    end
                    default: begin
                        st.mode  = MODE_IDLE;
                        run_idle = 1'b1;
                    end
                endcase

                if (run_idle) begin
                    if (i_state.ls && i_cfg.ind_on && (c == CH_SPACE || c == CH_TAB)) begin
                        st.cols   = csum[7] ? 7'd127 : csum[6:0];
                        measuring = 1'b1;
                    end else begin
                        if (i_state.ls && i_cfg.ind_on) begin
                            plan.ind_cnt = fl_cnt;
                            plan.ind_ex  = fl_ex;
                            st.prev      = level;
                            st.cols      = 7'd0;
                        end
                        if (c == CH_LF) begin
                            if (i_cfg.nl_on) begin
                                plan.main = plain_main(KIND_NEWLINE, CH_LF, 1'b1, 1'b1, 1'b1);
                            end
                            st.cols = 7'd0;
                        end else if (lc_len != 3'd0 &&
                                     delim_match(i_head, i_cfg.lc_text, lc_len)) begin
                            st.mode = MODE_LCOM;
                        end else if (bo_len != 3'd0 &&
                                     delim_match(i_head, i_cfg.bo_text, bo_len)) begin
                            st.mode = close_hit ? close_mode : MODE_BCOM;
                        end else if (c == CH_SPACE || c == CH_TAB) begin
                            st.mode = MODE_IDLE;
                        end else if (is_alpha(c)) begin
                            plan.main = plain_main(KIND_IDENT, c, 1'b1, 1'b1, !is_ident(nx));
                            if (is_ident(nx)) begin
                                st.mode = MODE_IDENT;
                            end
                        end else if (c == CH_0 && (nx | CH_SPACE) == CH_LOW_X) begin
                            plan.main = plain_main(KIND_INT, CH_0, 1'b1, 1'b1, 1'b0);
                            st.mode = MODE_HEXX;
                        end else if (is_digit(c)) begin
                            more = is_digit(nx) || nx == CH_DOT;
                            plan.main = plain_main(KIND_INT, c, 1'b1, 1'b1, !more);
                            if (more) begin
                                st.mode = MODE_DEC;
                            end
                        end else if (c == CH_DQUOTE) begin
                            plan.main = plain_main(KIND_STRING, CH_DQUOTE, 1'b1, 1'b1, 1'b0);
                            st.esc  = 1'b0;
                            st.mode = MODE_STR;
                        end else if (two_char_op(c, nx)) begin
                            plan.main = plain_main(KIND_OP, c, 1'b1, 1'b1, 1'b0);
                            st.mode = MODE_OP2;
                        end else if (c == CH_SQUOTE) begin
                            plan.main = plain_main(KIND_CHAR, CH_SQUOTE, 1'b1, 1'b1, 1'b0);
                            st.esc  = 1'b0;
                            st.mode = MODE_CHR;
                        end else begin
                            plan.main = plain_main(KIND_OP, c, 1'b1, 1'b1, 1'b1);
                        end
                    end
                end

                if (!measuring) begin
                    st.ls = (c == CH_LF);
                end
            end
            OP_QUOTE: begin
                if (i_state.mode == MODE_STR || i_state.mode == MODE_CHR) begin
                    if (i_state.esc) begin
                        plan.main = pair_main(kind, CH_NUL, q, 1'b1);
                    end else begin
                        plan.main = plain_main(kind, q, 1'b1, 1'b0, 1'b1);
                    end
                    st.ls = 1'b0;
                end
            end
            default: begin
                if (i_state.ls && i_cfg.ind_on) begin
                    plan.ind_cnt = fl_cnt;
                    plan.ind_ex  = fl_ex;
                end
                plan.main = plain_main(KIND_EOF, CH_NUL, 1'b0, 1'b1, 1'b1);
                st = '0;
            end
        endcase

        o_state = st;
        o_plan  = plan;
    end

endmodule

// ===== src/source_text_tokenizer.sv =====
// Streaming source text tokenizer. Bytes enter on the input channel one per
// transaction; i_end_marker closes the text. Each byte waits in a lookahead
// window of DELIM_BYTES entries and is lexed once the window is full, so the
// results of a byte appear DELIM_BYTES-1 transactions later. Every result
// carries at most one token byte: kind, byte, first/last flags and o_run_last
// on the final result caused by an input transaction (a transaction may cause
// none). Rate: a byte that yields at most one result lets plain text stream
// at one byte per clock unless the output stalls; more results hold the next
// byte back until the output serialiser, at one result a cycle unless
// stalled, has emitted all (up to 8 for an escape rewrite, plus one per
// indent or exdent token). At the end marker the bytes left in the window
// are lexed, an open quote is closed, the end-of-file result follows and no
// input is taken. Configuration must only be written while the block is idle.
module source_text_tokenizer import stt_pkg::*; #(
    parameter int DELIM_BYTES       = 4,
    parameter int MAX_INDENT_LEVELS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // text input
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_marker,
    // token output
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_token_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_has_byte,
    output logic        o_token_first,
    output logic        o_token_last,
    output logic        o_run_last
);

    localparam int FW = $clog2(DELIM_BYTES + 1);
    localparam logic [4:0] MAXL = 5'(MAX_INDENT_LEVELS);

    typedef enum logic [1:0] {FL_NONE, FL_HEADS, FL_EOF} t_flush;

    // Configuration
    t_cfg       r_cfg;
    t_cfg       n_cfg;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    // Lexer state and lookahead window
    logic [7:0] r_win [DELIM_BYTES];
    logic [7:0] n_win [DELIM_BYTES];
    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    t_lex_state r_state;
    t_lex_state n_state;
    t_flush     r_fl;
    t_flush     n_fl;

    // Result plan being serialised
    t_plan      r_plan;
    t_plan      n_plan;
    logic [3:0] r_midx;
    logic [3:0] n_midx;
    logic       r_run_end;
    logic       n_run_end;

    // Output register
    logic       r_out_valid;
    logic [3:0] r_out_kind;
    logic [7:0] r_out_byte;
    logic       r_out_has;
    logic       r_out_first;
    logic       r_out_last;
    logic       r_out_run_last;

    logic [7:0] win_a [DELIM_BYTES];
    logic [7:0] src [DELIM_BYTES];
    logic [FW-1:0] fill_a;
    logic [31:0] head;
    logic       pending;
    logic       final_res;
    logic       out_free;
    logic       emit_now;
    logic       slot;
    logic       take;
    logic       take_byte;
    logic       step_head;
    logic       step_quote;
    logic       step_eof;
    t_op        hd_op;
    t_lex_state hd_state;
    t_plan      hd_plan;
    logic [3:0] e_kind;
    logic [7:0] e_byte;
    logic       e_has;
    logic       e_first;
    logic       e_last;

    // Serialiser: indent/exdent tokens first, then the main bytes
    assign pending   = (r_plan.ind_cnt != 5'd0) || (r_midx < r_plan.main.len);
    assign final_res = (r_plan.ind_cnt == 5'd1 && r_plan.main.len == 4'd0) ||
                       (r_plan.ind_cnt == 5'd0 && r_midx + 4'd1 == r_plan.main.len);
    assign out_free  = !r_out_valid || i_ready;
    assign emit_now  = pending && out_free;
    // A new step may start once the current plan is drained or drains now
    assign slot      = !pending || (emit_now && final_res);

    assign take       = slot && r_fl == FL_NONE && r_in_valid;
    assign take_byte  = take && !r_in_end;
    assign fill_a     = r_fill + FW'(1);
    assign step_head  = (take_byte && fill_a == FW'(DELIM_BYTES)) ||
                        (slot && r_fl == FL_HEADS && r_fill != '0);
    assign step_quote = slot && r_fl == FL_HEADS && r_fill == '0;
    assign step_eof   = slot && r_fl == FL_EOF;
    assign hd_op      = step_eof ? OP_EOF : (step_quote ? OP_QUOTE : OP_HEAD);

    assign o_ready = !r_in_valid || take;

    // Append the incoming byte behind the filled entries
    always_comb begin
        for (int k = 0; k < DELIM_BYTES; k++) begin
            win_a[k] = (FW'(k) == r_fill) ? r_in_byte : r_win[k];
            src[k]   = take_byte ? win_a[k] : r_win[k];
        end
        for (int k = 0; k < 4; k++) begin
            head[8*k +: 8] = (k < DELIM_BYTES) ? src[k % DELIM_BYTES] : CH_NUL;
        end
    end

    stt_head #(
        .DELIM_BYTES       (DELIM_BYTES),
        .MAX_INDENT_LEVELS (MAX_INDENT_LEVELS)
    ) u_head (
        .i_op    (hd_op),
        .i_head  (head),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_state (hd_state),
        .o_plan  (hd_plan)
    );

    // Pick the result under the serialiser
    always_comb begin
        if (r_plan.ind_cnt != 5'd0) begin
            e_kind  = r_plan.ind_ex ? KIND_EXDENT : KIND_INDENT;
            e_byte  = CH_NUL;
            e_has   = 1'b0;
            e_first = 1'b1;
            e_last  = 1'b1;
        end else begin
            e_kind  = r_plan.main.kind;
            e_has   = r_plan.main.has;
            e_byte  = r_plan.main.has ? main_byte(r_plan.main, r_midx) : CH_NUL;
            e_first = r_plan.main.first && r_midx == 4'd0;
            e_last  = r_plan.main.last && r_midx + 4'd1 == r_plan.main.len;
        end
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_NEWLINE_ON:  n_cfg.nl_on   = i_cfg_data[0];
                REG_INDENT_ON:   n_cfg.ind_on  = i_cfg_data[0];
                REG_LINE_LEN:    n_cfg.lc_len  = i_cfg_data[2:0];
                REG_LINE_TEXT:   n_cfg.lc_text = i_cfg_data;
                REG_BOPEN_LEN:   n_cfg.bo_len  = i_cfg_data[2:0];
                REG_BOPEN_TEXT:  n_cfg.bo_text = i_cfg_data;
                REG_BCLOSE_LEN:  n_cfg.bc_len  = i_cfg_data[2:0];
                REG_BCLOSE_TEXT: n_cfg.bc_text = i_cfg_data;
            endcase
        end
    end

    always_comb begin
        n_win     = r_win;
        n_fill    = r_fill;
        n_state   = r_state;
        n_fl      = r_fl;
        n_plan    = r_plan;
        n_midx    = r_midx;
        n_run_end = r_run_end;

        // advance the serialiser
        if (emit_now) begin
            if (r_plan.ind_cnt != 5'd0) begin
                n_plan.ind_cnt = r_plan.ind_cnt - 5'd1;
            end else begin
                n_midx = r_midx + 4'd1;
            end
        end

        if (take_byte) begin
            n_win  = win_a;
            n_fill = fill_a;
        end
        if (take && r_in_end) begin
            n_fl = FL_HEADS;
        end

        // consume the head byte: shift the window down, zero behind
        if (step_head) begin
            for (int k = 0; k < DELIM_BYTES; k++) begin
                n_win[k] = (k < DELIM_BYTES - 1) ? src[(k + 1) % DELIM_BYTES] : CH_NUL;
            end
            n_fill  = (take_byte ? fill_a : r_fill) - FW'(1);
            n_state = hd_state;
        end
        if (step_quote) begin
            n_state = hd_state;
            n_fl    = FL_EOF;
        end
        if (step_eof) begin
            n_state = hd_state;
            for (int k = 0; k < DELIM_BYTES; k++) begin
                n_win[k] = CH_NUL;
            end
            n_fill = '0;
            n_fl   = FL_NONE;
        end

        // load the next plan over the drained one
        if (step_head || step_quote || step_eof) begin
            n_plan    = hd_plan;
            n_midx    = 4'd0;
            n_run_end = step_eof || take_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg          <= '{1'b0, 1'b0, 3'd0, 32'd0, 3'd0, 32'd0, 3'd1, 32'd0};
            r_in_valid     <= 1'b0;
            r_fill         <= '0;
            r_state        <= '0;
            r_fl           <= FL_NONE;
            r_plan         <= '0;
            r_midx         <= 4'd0;
            r_run_end      <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int k = 0; k < DELIM_BYTES; k++) begin
                r_win[k] <= CH_NUL;
            end
        end else begin
            r_cfg     <= n_cfg;
            r_win     <= n_win;
            r_fill    <= n_fill;
            r_state   <= n_state;
            r_fl      <= n_fl;
            r_plan    <= n_plan;
            r_midx    <= n_midx;
            r_run_end <= n_run_end;
            // hold the input transaction until the engine takes it
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (emit_now) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_ready) begin
            r_in_byte <= i_text_byte;
            r_in_end  <= i_end_marker;
        end
        if (emit_now) begin
            r_out_kind     <= e_kind;
            r_out_byte     <= e_byte;
            r_out_has      <= e_has;
            r_out_first    <= e_first;
            r_out_last     <= e_last;
            r_out_run_last <= final_res && r_run_end;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_token_kind  = r_out_kind;
    assign o_out_byte    = r_out_byte;
    assign o_has_byte    = r_out_has;
    assign o_token_first = r_out_first;
    assign o_token_last  = r_out_last;
    assign o_run_last    = r_out_run_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DELIM_BYTES))
        else $error("lookahead fill beyond window depth");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.prev <= MAXL)
        else $error("indent level beyond maximum");

    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_eof |=> (r_fill == '0 && r_state.mode == MODE_IDLE && r_fl == FL_NONE))
        else $error("stream state not cleared after end of file");

    a_no_take_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fl != FL_NONE) |-> !take)
        else $error("input taken during end-of-text flush");

    a_plan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plan.main.len <= 4'd8)
        else $error("result plan longer than an escape rewrite");

endmodule
